// File: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants, opcode and state types for the sum tree sampler.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Tree geometry: node 0 is the root, children of i are 2i+1 and 2i+2.
  localparam int LEAVES     = 512;
  localparam int NODES      = 2 * LEAVES - 1;
  localparam int LEAF_FIRST = LEAVES - 1;
  localparam int ADDR_W     = $clog2(NODES);

  // Fixed field widths of the channels.
  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_PROPAGATE = 2'd1,
    OP_RETRIEVE  = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROP,
    ST_RETR,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

// File: sv/sts_if.sv
// ----------------------------------------------------------------------------
// sts_in_if / sts_out_if
// Valid/ready channels for sampler requests and sampler results.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic                                valid;
  logic                                ready;
  logic [sts_pkg::OP_W-1:0]            opcode;
  logic [sts_pkg::IDX_W-1:0]           node_index;
  logic [sts_pkg::VAL_W-1:0]           node_value;
  logic signed [sts_pkg::VAL_W-1:0]    change_amount;
  logic [sts_pkg::VAL_W-1:0]           sample_value;

  modport source (output valid, opcode, node_index, node_value, change_amount,
                  sample_value, input ready);
  modport sink   (input valid, opcode, node_index, node_value, change_amount,
                  sample_value, output ready);
endinterface

interface sts_out_if;
  logic                                valid;
  logic                                ready;
  logic [sts_pkg::IDX_W-1:0]           result_index;
  logic [sts_pkg::VAL_W-1:0]           result_value;
  logic                                saturated;

  modport source (output valid, result_index, result_value, saturated,
                  input ready);
  modport sink   (input valid, result_index, result_value, saturated,
                  output ready);
endinterface

// File: sv/sum_tree_sampler.sv
// ----------------------------------------------------------------------------
// sum_tree_sampler
// Array-stored binary sum tree of unsigned Q16.16 priorities kept in one
// single-port-read, single-port-write synchronous memory.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; the next transfer is taken in the cycle after
//   the result is loaded into the output register. Propagate and retrieve walk
//   one tree level per memory read, so a full walk sets the interval.
// Reset: rst_n clears control state, then a clearing pass zeroes all NODES
//   entries, one per cycle, with ready held low.
// ----------------------------------------------------------------------------
module sum_tree_sampler (
  input  logic        clk,
  input  logic        rst_n,
  sts_in_if.sink      in_ch,
  sts_out_if.source   out_ch
);

  localparam int AW = sts_pkg::ADDR_W;
  localparam int IW = sts_pkg::IDX_W;
  localparam int VW = sts_pkg::VAL_W;

  // Node storage: one write and one registered read per cycle.
  logic [VW-1:0] mem [0:sts_pkg::NODES-1];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [VW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Control and working registers.
  sts_pkg::state_t     state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]       node_r, node_nxt;
  logic signed [VW-1:0] delta_r, delta_nxt;
  logic [VW-1:0]       sample_r, sample_nxt;
  logic                range_r, range_nxt;
  logic                sat_r, sat_nxt;

  // Result waiting for the output register.
  logic [IW-1:0]       res_index_r, res_index_nxt;
  logic [VW-1:0]       res_value_r, res_value_nxt;
  logic                res_sat_r, res_sat_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [IW-1:0]       out_index_r, out_index_nxt;
  logic [VW-1:0]       out_value_r, out_value_nxt;
  logic                out_sat_r, out_sat_nxt;

  // Request decode.
  sts_pkg::op_t  in_op;
  logic          in_xfer;
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] in_addr_m1;
  logic [AW-1:0] in_parent;
  logic          in_is_root;

  assign in_ch.ready = (state_r == sts_pkg::ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_op       = sts_pkg::op_t'(in_ch.opcode);
  assign in_range    = 32'(in_ch.node_index) < sts_pkg::NODES;
  assign in_addr     = AW'(in_ch.node_index);
  assign in_addr_m1  = in_addr - AW'(1);
  assign in_parent   = {1'b0, in_addr_m1[AW-1:1]};
  assign in_is_root  = (in_ch.node_index == '0);

  // Propagate step: saturating add of the signed change to the node just read.
  logic signed [VW+1:0] prop_sum;
  logic                 prop_neg;
  logic                 prop_over;
  logic [VW-1:0]        prop_val;
  logic [AW-1:0]        node_m1;
  logic [AW-1:0]        node_parent;
  logic                 node_is_root;

  assign prop_sum     = $signed({2'b00, rd_data_r}) + (VW+2)'(delta_r);
  assign prop_neg     = prop_sum[VW+1];
  assign prop_over    = !prop_sum[VW+1] && prop_sum[VW];
  assign prop_val     = prop_neg  ? '0 :
                        prop_over ? '1 : prop_sum[VW-1:0];
  assign node_m1      = node_r - AW'(1);
  assign node_parent  = {1'b0, node_m1[AW-1:1]};
  assign node_is_root = (node_r == '0);

  // Retrieve step: compare sample against the left child sum just read.
  logic [AW-1:0] retr_left;
  logic          retr_go_left;
  logic [AW-1:0] retr_next;
  logic [AW-1:0] retr_next_left;
  logic          retr_at_leaf;

  assign retr_left      = {node_r[AW-2:0], 1'b1};
  assign retr_go_left   = (sample_r <= rd_data_r);
  assign retr_next      = retr_go_left ? retr_left : retr_left + AW'(1);
  assign retr_next_left = {retr_next[AW-2:0], 1'b1};
  assign retr_at_leaf   = 32'(retr_next) >= sts_pkg::LEAF_FIRST;

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sts_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(sts_pkg::NODES - 1)) begin
          state_nxt = sts_pkg::ST_IDLE;
        end
      end
      sts_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_op)
            sts_pkg::OP_WRITE:     state_nxt = sts_pkg::ST_DONE;
            sts_pkg::OP_PROPAGATE: state_nxt = (in_range && !in_is_root) ?
                                               sts_pkg::ST_PROP : sts_pkg::ST_DONE;
            sts_pkg::OP_RETRIEVE:  state_nxt = sts_pkg::ST_RETR;
            sts_pkg::OP_READ:      state_nxt = sts_pkg::ST_READ;
            default:               state_nxt = sts_pkg::ST_DONE;
          endcase
        end
      end
      sts_pkg::ST_PROP: begin
        if (node_is_root) begin
          state_nxt = sts_pkg::ST_DONE;
        end
      end
      sts_pkg::ST_RETR: begin
        if (retr_at_leaf) begin
          state_nxt = sts_pkg::ST_DONE;
        end
      end
      sts_pkg::ST_READ: state_nxt = sts_pkg::ST_DONE;
      sts_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sts_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory control and result registers.
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = prop_val;
    mem_raddr     = node_r;
    clr_cnt_nxt   = clr_cnt_r;
    node_nxt      = node_r;
    delta_nxt     = delta_r;
    sample_nxt    = sample_r;
    range_nxt     = range_r;
    sat_nxt       = sat_r;
    res_index_nxt = res_index_r;
    res_value_nxt = res_value_r;
    res_sat_nxt   = res_sat_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      sts_pkg::ST_CLEAR: begin
        // Zero one entry per cycle.
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      sts_pkg::ST_IDLE: begin
        if (in_xfer) begin
          delta_nxt     = in_ch.change_amount;
          sample_nxt    = in_ch.sample_value;
          range_nxt     = in_range;
          sat_nxt       = 1'b0;
          res_index_nxt = in_ch.node_index;
          res_value_nxt = '0;
          res_sat_nxt   = 1'b0;
          unique case (in_op)
            sts_pkg::OP_WRITE: begin
              mem_we    = in_range;
              mem_waddr = in_addr;
              mem_wdata = in_ch.node_value;
            end
            sts_pkg::OP_PROPAGATE: begin
              // Fetch the parent first; the walk climbs from there.
              node_nxt  = in_parent;
              mem_raddr = in_parent;
            end
            sts_pkg::OP_RETRIEVE: begin
              // Start at the root and fetch its left child sum.
              node_nxt  = '0;
              mem_raddr = AW'(1);
            end
            sts_pkg::OP_READ: begin
              mem_raddr = in_addr;
            end
            default: ;
          endcase
        end
      end
      sts_pkg::ST_PROP: begin
        // Write back this ancestor and fetch the next one up.
        mem_we      = 1'b1;
        mem_waddr   = node_r;
        mem_wdata   = prop_val;
        sat_nxt     = sat_r | prop_neg | prop_over;
        node_nxt    = node_parent;
        mem_raddr   = node_parent;
        res_sat_nxt = sat_r | prop_neg | prop_over;
      end
      sts_pkg::ST_RETR: begin
        node_nxt   = retr_next;
        mem_raddr  = retr_next_left;
        if (!retr_go_left) begin
          sample_nxt = sample_r - rd_data_r;
        end
        res_index_nxt = IW'(retr_next);
      end
      sts_pkg::ST_READ: begin
        res_value_nxt = range_r ? rd_data_r : '0;
      end
      sts_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_index_r;
          out_value_nxt = res_value_r;
          out_sat_nxt   = res_sat_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sts_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    delta_r     <= delta_nxt;
    sample_r    <= sample_nxt;
    range_r     <= range_nxt;
    sat_r       <= sat_nxt;
    res_index_r <= res_index_nxt;
    res_value_r <= res_value_nxt;
    res_sat_r   <= res_sat_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.saturated    = out_sat_r;

endmodule
